// ===== hdl/pcd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the periodic cutoff distance block: widths, register map,
// configuration bundle. No dependencies.

package pcd_pkg;

    // Default coordinate width, handed to the top-level parameter
    localparam int COORD_BITS_DEF = 20;

    // Fixed field widths
    localparam int BOX_W  = 19;
    localparam int CUT_W  = 21;
    localparam int IDX_W  = 20;
    localparam int DIST_W = 21;

    // Per-axis separation clamps at 2^DIST_W, so it needs one bit more
    localparam int SEP_W  = DIST_W + 1;
    localparam logic [SEP_W-1:0] SEP_MAX = SEP_W'(1) << DIST_W;

    // Square of a clamped separation, sum of three squares, root of the sum
    localparam int SQ_W   = 2 * DIST_W + 1;
    localparam int SUM_W  = SQ_W + 1;
    localparam int ROOT_W = SUM_W / 2;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Pipeline shape: three axis stages, one sum stage, one root bit per stage
    localparam int AXIS_STAGES = 3;
    localparam int PIPE_STAGES = AXIS_STAGES + 1 + ROOT_W;

    // APB register map
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_BOX_LENGTH = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_CUTOFF     = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_SLAB_MODE  = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_CENTER_X   = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y   = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Z   = REG_IDX_W'(5);

    // Width-fixed configuration, shared by the register file and the datapath
    typedef struct packed {
        logic [BOX_W-1:0] box_length;
        logic [CUT_W-1:0] cutoff;     // two's complement, sign bit = take all
        logic             slab_mode;
    } cfg_t;

endpackage

// ===== hdl/periodic_cutoff_distance.sv =====
`timescale 1ns / 1ps
// Top level of the periodic cutoff distance block: APB registers, three axis
// pipes, sum, root pipe, result register with skid. Depends on pcd_pkg,
// pcd_regs, pcd_axis, pcd_sqrt.
//
//   channel   direction  handshake              payload
//   s_        in         s_valid / s_ready      atom_x/y/z, atom_index, excluded
//   m_        out        m_valid / m_ready      out_index, distance, selected
//   apb       in         psel, penable, pready  paddr, pwdata / prdata
//
// One item per cycle while the skid entry is free; items reach m_ via three
// axis stages, one sum stage, 22 root stages (one bit each), result register.
// The whole pipe advances on one enable; it stalls only when the result
// register and its skid entry both hold items, so s_ready is a flop output.
// Synchronous active-low reset empties the pipe and restores the registers.

module periodic_cutoff_distance #(
    parameter int COORD_BITS = pcd_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [COORD_BITS-1:0]    s_atom_x,
    input  logic signed [COORD_BITS-1:0]    s_atom_y,
    input  logic signed [COORD_BITS-1:0]    s_atom_z,
    input  logic [pcd_pkg::IDX_W-1:0]       s_atom_index,
    input  logic                            s_excluded,
    // result items
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pcd_pkg::IDX_W-1:0]       m_out_index,
    output logic [pcd_pkg::DIST_W-1:0]      m_distance,
    output logic                            m_selected,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pcd_pkg::ADDR_W-1:0]      paddr,
    input  logic [pcd_pkg::DATA_W-1:0]      pwdata,
    output logic [pcd_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    localparam int P = pcd_pkg::PIPE_STAGES;

    pcd_pkg::cfg_t                  cfg;
    logic signed [COORD_BITS-1:0]   center_x, center_y, center_z;

    logic                           adv;
    logic [P-1:0]                   v_reg;
    logic [pcd_pkg::IDX_W-1:0]      idx_reg  [P];
    logic                           excl_reg [P];

    logic [pcd_pkg::SQ_W-1:0]       sq_x, sq_y, sq_z;
    logic [pcd_pkg::SUM_W-1:0]      sum_next, sum_reg;
    logic [pcd_pkg::ROOT_W-1:0]     root;

    logic                           take;
    logic [pcd_pkg::DIST_W-1:0]     tail_dist;
    logic                           tail_sel;

    logic                           out_valid_reg;
    logic [pcd_pkg::IDX_W-1:0]      out_index_reg;
    logic [pcd_pkg::DIST_W-1:0]     out_dist_reg;
    logic                           out_sel_reg;
    logic                           skid_valid_reg;
    logic [pcd_pkg::IDX_W-1:0]      skid_index_reg;
    logic [pcd_pkg::DIST_W-1:0]     skid_dist_reg;
    logic                           skid_sel_reg;

    // Configuration registers
    pcd_regs #(.COORD_BITS(COORD_BITS)) u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .center_x (center_x),
        .center_y (center_y),
        .center_z (center_z)
    );

    // Pipe moves whenever the skid entry is free
    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    // Valid bits and pass-through fields travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[P-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx_reg[0]  <= s_atom_index;
            excl_reg[0] <= s_excluded;
            for (int i = 1; i < P; i++) begin
                idx_reg[i]  <= idx_reg[i-1];
                excl_reg[i] <= excl_reg[i-1];
            end
        end
    end

    // Axis pipes; z folds only outside slab mode
    pcd_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .aclk       (aclk),
        .en         (adv),
        .fold_en    (1'b1),
        .box_length (cfg.box_length),
        .center     (center_x),
        .atom       (s_atom_x),
        .sq         (sq_x)
    );

    pcd_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .aclk       (aclk),
        .en         (adv),
        .fold_en    (1'b1),
        .box_length (cfg.box_length),
        .center     (center_y),
        .atom       (s_atom_y),
        .sq         (sq_y)
    );

    pcd_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (
        .aclk       (aclk),
        .en         (adv),
        .fold_en    (!cfg.slab_mode),
        .box_length (cfg.box_length),
        .center     (center_z),
        .atom       (s_atom_z),
        .sq         (sq_z)
    );

    // Sum of squares
    assign sum_next = pcd_pkg::SUM_W'(sq_x) + pcd_pkg::SUM_W'(sq_y)
                    + pcd_pkg::SUM_W'(sq_z);

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg <= sum_next;
        end
    end

    // Root pipe
    pcd_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (adv),
        .radicand (sum_reg),
        .root     (root)
    );

    // Saturate and apply the cutoff test at the tail of the pipe
    always_comb begin
        if (root > pcd_pkg::ROOT_W'(pcd_pkg::DIST_MAX)) begin
            tail_dist = pcd_pkg::DIST_MAX;
        end else begin
            tail_dist = root[pcd_pkg::DIST_W-1:0];
        end
        tail_sel = !excl_reg[P-1]
                && (cfg.cutoff[pcd_pkg::CUT_W-1] || (tail_dist <= cfg.cutoff));
    end

    assign take = adv && v_reg[P-1];

    // Result register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (take) begin
            if (!out_valid_reg || m_ready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_index_reg <= skid_index_reg;
                out_dist_reg  <= skid_dist_reg;
                out_sel_reg   <= skid_sel_reg;
            end
        end else if (take) begin
            if (!out_valid_reg || m_ready) begin
                out_index_reg <= idx_reg[P-1];
                out_dist_reg  <= tail_dist;
                out_sel_reg   <= tail_sel;
            end else begin
                skid_index_reg <= idx_reg[P-1];
                skid_dist_reg  <= tail_dist;
                skid_sel_reg   <= tail_sel;
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_index = out_index_reg;
    assign m_distance  = out_dist_reg;
    assign m_selected  = out_sel_reg;

endmodule

// ===== hdl/pcd_regs.sv =====
`timescale 1ns / 1ps
// APB register file for the periodic cutoff distance block.
// Depends on pcd_pkg.

module pcd_regs #(
    parameter int COORD_BITS = pcd_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcd_pkg::ADDR_W-1:0]    paddr,
    input  logic [pcd_pkg::DATA_W-1:0]    pwdata,
    output logic [pcd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output pcd_pkg::cfg_t                 cfg,
    output logic signed [COORD_BITS-1:0]  center_x,
    output logic signed [COORD_BITS-1:0]  center_y,
    output logic signed [COORD_BITS-1:0]  center_z
);

    pcd_pkg::cfg_t                  cfg_reg;
    logic signed [COORD_BITS-1:0]   center_x_reg;
    logic signed [COORD_BITS-1:0]   center_y_reg;
    logic signed [COORD_BITS-1:0]   center_z_reg;
    logic [pcd_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[pcd_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes; unknown indexes fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.box_length <= '0;
            cfg_reg.cutoff     <= '1;
            cfg_reg.slab_mode  <= 1'b0;
            center_x_reg       <= '0;
            center_y_reg       <= '0;
            center_z_reg       <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                pcd_pkg::REG_BOX_LENGTH: cfg_reg.box_length <= pwdata[pcd_pkg::BOX_W-1:0];
                pcd_pkg::REG_CUTOFF:     cfg_reg.cutoff     <= pwdata[pcd_pkg::CUT_W-1:0];
                pcd_pkg::REG_SLAB_MODE:  cfg_reg.slab_mode  <= pwdata[0];
                pcd_pkg::REG_CENTER_X:   center_x_reg       <= pwdata[COORD_BITS-1:0];
                pcd_pkg::REG_CENTER_Y:   center_y_reg       <= pwdata[COORD_BITS-1:0];
                pcd_pkg::REG_CENTER_Z:   center_z_reg       <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read mux, signed registers sign-extended
    always_comb begin
        unique case (reg_idx)
            pcd_pkg::REG_BOX_LENGTH: prdata = pcd_pkg::DATA_W'(cfg_reg.box_length);
            pcd_pkg::REG_CUTOFF:     prdata = pcd_pkg::DATA_W'(signed'(cfg_reg.cutoff));
            pcd_pkg::REG_SLAB_MODE:  prdata = pcd_pkg::DATA_W'(cfg_reg.slab_mode);
            pcd_pkg::REG_CENTER_X:   prdata = pcd_pkg::DATA_W'(center_x_reg);
            pcd_pkg::REG_CENTER_Y:   prdata = pcd_pkg::DATA_W'(center_y_reg);
            pcd_pkg::REG_CENTER_Z:   prdata = pcd_pkg::DATA_W'(center_z_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg      = cfg_reg;
    assign center_x = center_x_reg;
    assign center_y = center_y_reg;
    assign center_z = center_z_reg;

endmodule

// ===== hdl/pcd_axis.sv =====
`timescale 1ns / 1ps
// One axis of the distance pipeline: absolute difference, minimum-image
// fold with clamp, square. Three register stages. Depends on pcd_pkg.

module pcd_axis #(
    parameter int COORD_BITS = pcd_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            en,
    input  logic                            fold_en,
    input  logic [pcd_pkg::BOX_W-1:0]       box_length,
    input  logic signed [COORD_BITS-1:0]    center,
    input  logic signed [COORD_BITS-1:0]    atom,
    output logic [pcd_pkg::SQ_W-1:0]        sq
);

    localparam int DW = COORD_BITS + 1;
    localparam int AW = (DW > pcd_pkg::SEP_W) ? DW : pcd_pkg::SEP_W;

    logic signed [DW-1:0]              diff;
    logic [DW-1:0]                     abs_next, abs_reg;
    logic [AW-1:0]                     t_w, box_w, fold_w;
    logic                              do_fold;
    logic [pcd_pkg::SEP_W-1:0]         sep_next, sep_reg;
    logic [2*pcd_pkg::SEP_W-1:0]       prod;
    logic [pcd_pkg::SQ_W-1:0]          sq_next, sq_reg;

    // Stage 1: |center - atom|
    always_comb begin
        diff     = DW'(center) - DW'(atom);
        abs_next = diff[DW-1] ? unsigned'(-diff) : unsigned'(diff);
    end

    // Stage 2: if enabled, fold once when twice the separation exceeds a non-zero box; then clamp to SEP_MAX
    always_comb begin
        t_w     = AW'(abs_reg);
        box_w   = AW'(box_length);
        do_fold = fold_en && (box_length != '0) && ({t_w, 1'b0} > {1'b0, box_w});
        if (do_fold) begin
            fold_w = (t_w > box_w) ? (t_w - box_w) : (box_w - t_w);
        end else begin
            fold_w = t_w;
        end
        if (fold_w > AW'(pcd_pkg::SEP_MAX)) begin
            sep_next = pcd_pkg::SEP_MAX;
        end else begin
            sep_next = fold_w[pcd_pkg::SEP_W-1:0];
        end
    end

    // Stage 3: square; clamped input keeps it within SQ_W bits
    always_comb begin
        prod    = sep_reg * sep_reg;
        sq_next = prod[pcd_pkg::SQ_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            abs_reg <= abs_next;
            sep_reg <= sep_next;
            sq_reg  <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

// ===== hdl/pcd_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root (floor), one root bit resolved per stage.
// Depends on pcd_pkg.

module pcd_sqrt (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [pcd_pkg::SUM_W-1:0]    radicand,
    output logic [pcd_pkg::ROOT_W-1:0]   root
);

    localparam int SW = pcd_pkg::SUM_W;
    localparam int RW = pcd_pkg::ROOT_W;

    logic [SW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];

    // Remainder holds radicand - root^2; each stage tries the next lower bit
    for (genvar s = 0; s < RW; s++) begin : g_stage
        localparam int K = RW - 1 - s;

        logic [SW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [SW:0]   trial;
        logic [SW-1:0] rem_next;
        logic [RW-1:0] root_next;

        if (s == 0) begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        // (root + 2^K)^2 - root^2 = root * 2^(K+1) + 2^(2K)
        always_comb begin
            trial = ({1'b0, SW'(root_in)} << (K + 1)) + ((SW + 1)'(1) << (2 * K));
            if ({1'b0, rem_in} >= trial) begin
                rem_next  = rem_in - trial[SW-1:0];
                root_next = root_in | (RW'(1) << K);
            end else begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule
